[hdl/aoc_pkg.sv]
// ----------------------------------------------------------------------------
// aoc_pkg
// types and constants shared by the alpha over compositor
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DEN_W       = 3 * SAMPLE_BITS;
    localparam int NUM_W       = 4 * SAMPLE_BITS;
    localparam int FRONT_ST    = 4;
    localparam int DIV_ST      = SAMPLE_BITS;
    localparam int N_COL       = 3;

    localparam logic [SAMPLE_BITS-1:0]   FS  = {SAMPLE_BITS{1'b1}};
    localparam logic [2*SAMPLE_BITS-1:0] FS2 = (2*SAMPLE_BITS)'(FS) * (2*SAMPLE_BITS)'(FS);

    localparam logic [1:0] CFG_OPACITY   = 2'd0;
    localparam logic [1:0] CFG_BASE_CHAN = 2'd1;
    localparam logic [1:0] CFG_OVER_ALPH = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] base_red;
        logic [SAMPLE_BITS-1:0] base_green;
        logic [SAMPLE_BITS-1:0] base_blue;
        logic [SAMPLE_BITS-1:0] base_alpha;
        logic [SAMPLE_BITS-1:0] over_red;
        logic [SAMPLE_BITS-1:0] over_green;
        logic [SAMPLE_BITS-1:0] over_blue;
        logic [SAMPLE_BITS-1:0] over_alpha;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_red;
        logic [SAMPLE_BITS-1:0] out_green;
        logic [SAMPLE_BITS-1:0] out_blue;
        logic [SAMPLE_BITS-1:0] out_alpha;
    } t_out;

    typedef struct packed {
        logic [15:0] opacity;
        logic [1:0]  ncol;
        logic        alpha_used;
        logic        over_alpha;
    } t_cfg;

    typedef struct packed {
        logic [1:0]             ncol;
        logic                   alpha_used;
        logic                   rzero;
        logic [SAMPLE_BITS-1:0] alpha;
    } t_side;

endpackage

[hdl/aoc_front.sv]
// ----------------------------------------------------------------------------
// aoc_front
// alpha products, combined alpha and blended numerators per channel
// ----------------------------------------------------------------------------
module aoc_front (
    input  logic                                   i_clk,
    input  logic [aoc_pkg::FRONT_ST-1:0]           i_en,
    input  aoc_pkg::t_in                           i_data,
    input  aoc_pkg::t_cfg                          i_cfg,
    output logic [aoc_pkg::N_COL-1:0][aoc_pkg::NUM_W-1:0] o_num,
    output logic [aoc_pkg::DEN_W-1:0]              o_den,
    output aoc_pkg::t_side                         o_side
);
    localparam int SB = aoc_pkg::SAMPLE_BITS;

    logic [SB-1:0]   w_a1, w_a2;
    logic [2*SB-1:0] r_p;
    logic [SB-1:0]   r_a1;
    logic [aoc_pkg::N_COL-1:0][SB-1:0] r_cb1, r_co1, r_cb2, r_co2;
    aoc_pkg::t_side  r_s1, r_s2, r_s3, r_s4;
    logic [2*SB-1:0] w_q;
    logic [aoc_pkg::DEN_W-1:0] r_a1q, r_pfs, r_r3, r_r4;
    logic [aoc_pkg::N_COL-1:0][aoc_pkg::NUM_W-1:0] r_m1, r_m2, r_num;

    logic [SB-1:0]   r_ph, r_pl, r_d, r_a1b, r_a1c, r_a1d;
    logic [2*SB-1:0] r_phd, r_pld, r_y1;
    logic [2*SB:0]   w_psum, w_tsum, w_asum;
    logic [SB-1:0]   w_ph, w_t, w_qy, w_alpha;
    logic [2*SB-1:0] w_phfs;

    assign w_a1 = i_cfg.alpha_used ? i_data.base_alpha : aoc_pkg::FS;
    assign w_a2 = i_cfg.over_alpha ? i_data.over_alpha : aoc_pkg::FS;
    assign w_q  = aoc_pkg::FS2 - r_p;

    // division by full scale as shift and add, exact below 2^32 - 1
    assign w_psum = (2*SB+1)'(r_p) + (2*SB+1)'(r_p[2*SB-1:SB]) + (2*SB+1)'(1);
    assign w_ph   = SB'(w_psum >> SB);
    assign w_phfs = {w_ph, {SB{1'b0}}} - (2*SB)'(w_ph);

    assign w_tsum = (2*SB+1)'(r_pld) + (2*SB+1)'(r_pld[2*SB-1:SB]) + (2*SB+1)'(1);
    assign w_t    = SB'(w_tsum >> SB);

    assign w_asum  = (2*SB+1)'(r_y1) + (2*SB+1)'(r_y1[2*SB-1:SB]) + (2*SB+1)'(1);
    assign w_qy    = SB'(w_asum >> SB);
    assign w_alpha = r_a1d + w_qy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p   <= (2*SB)'(w_a2) * (2*SB)'(i_cfg.opacity);
            r_a1  <= w_a1;
            r_cb1 <= {i_data.base_red, i_data.base_green, i_data.base_blue};
            r_co1 <= {i_data.over_red, i_data.over_green, i_data.over_blue};
            r_s1  <= '{ncol: i_cfg.ncol, alpha_used: i_cfg.alpha_used, rzero: 1'b0,
                       alpha: '0};
        end
        if (i_en[1]) begin
            r_a1q <= aoc_pkg::DEN_W'(r_a1) * aoc_pkg::DEN_W'(w_q);
            r_pfs <= {r_p, {SB{1'b0}}} - aoc_pkg::DEN_W'(r_p);
            r_ph  <= w_ph;
            r_pl  <= SB'(r_p - w_phfs);
            r_d   <= aoc_pkg::FS - r_a1;
            r_a1b <= r_a1;
            r_cb2 <= r_cb1;
            r_co2 <= r_co1;
            r_s2  <= r_s1;
        end
        if (i_en[2]) begin
            for (int j = 0; j < aoc_pkg::N_COL; j++) begin
                r_m1[j] <= aoc_pkg::NUM_W'(r_pfs) * aoc_pkg::NUM_W'(r_co2[j]);
                r_m2[j] <= aoc_pkg::NUM_W'(r_a1q) * aoc_pkg::NUM_W'(r_cb2[j]);
            end
            r_r3  <= r_pfs + r_a1q;
            r_phd <= (2*SB)'(r_ph) * (2*SB)'(r_d);
            r_pld <= (2*SB)'(r_pl) * (2*SB)'(r_d);
            r_a1c <= r_a1b;
            r_s3  <= r_s2;
        end
        if (i_en[3]) begin
            for (int j = 0; j < aoc_pkg::N_COL; j++) begin
                r_num[j] <= r_m1[j] + r_m2[j];
            end
            r_r4  <= r_r3;
            r_y1  <= r_phd + (2*SB)'(w_t);
            r_a1d <= r_a1c;
            r_s4  <= '{ncol: r_s3.ncol, alpha_used: r_s3.alpha_used, rzero: (r_r3 == '0),
                       alpha: '0};
        end
    end

    assign o_num = r_num;
    assign o_den = r_r4;

    // combined alpha is base alpha plus the overlay share over full scale squared
    always_comb begin
        o_side       = r_s4;
        o_side.alpha = w_alpha;
    end
endmodule

[hdl/aoc_div_lane.sv]
// ----------------------------------------------------------------------------
// aoc_div_lane
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module aoc_div_lane (
    input  logic                              i_clk,
    input  logic [aoc_pkg::DIV_ST-1:0]        i_en,
    input  logic [aoc_pkg::NUM_W-1:0]         i_num,
    input  logic [aoc_pkg::DEN_W-1:0]         i_den,
    output logic [aoc_pkg::SAMPLE_BITS-1:0]   o_quo
);
    localparam int NS = aoc_pkg::DIV_ST;
    localparam int NW = aoc_pkg::NUM_W;
    localparam int SB = aoc_pkg::SAMPLE_BITS;

    logic [NS-1:0][NW-1:0]             r_rem;
    logic [NS-1:0][aoc_pkg::DEN_W-1:0] r_den;
    logic [NS-1:0][SB-1:0]             r_quo;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [NW-1:0]             w_rem;
        logic [aoc_pkg::DEN_W-1:0] w_den;
        logic [SB-1:0]             w_quo;
        logic [NW-1:0]             w_sh;
        logic                      w_ge;

        if (s == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_quo = r_quo[s-1];
        end

        assign w_sh = NW'(w_den) << (NS - 1 - s);
        assign w_ge = (w_rem >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= w_ge ? (w_rem - w_sh) : w_rem;
                r_den[s] <= w_den;
                r_quo[s] <= {w_quo[SB-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[NS-1];
endmodule

[hdl/alpha_over_composite_with_opacity.sv]
// ----------------------------------------------------------------------------
// alpha_over_composite_with_opacity
// porter-duff over compositing of an overlay pixel onto a base pixel
// ----------------------------------------------------------------------------
// One pixel pair is accepted per clock unless the pipeline holds. Each pair passes
// the front stages of alpha and channel products, then a 16-stage divider, one per
// colour lane. The combined alpha is derived from the alpha products with shift
// and add steps and travels beside the lanes. All stages advance together; the
// pipeline holds only while a finished result is not taken.
module alpha_over_composite_with_opacity (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  aoc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output aoc_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    localparam int NF = aoc_pkg::FRONT_ST;
    localparam int ND = aoc_pkg::DIV_ST;
    localparam int NT = NF + ND;
    localparam int SB = aoc_pkg::SAMPLE_BITS;

    logic [15:0] r_opacity;
    logic [2:0]  r_bcc;
    logic        r_oha;
    logic [2:0]  w_chans;
    aoc_pkg::t_cfg w_cfg;

    logic [NT-1:0] r_v;
    logic [NT-1:0] w_en;
    logic          w_go;

    logic [aoc_pkg::N_COL-1:0][aoc_pkg::NUM_W-1:0] w_num;
    logic [aoc_pkg::DEN_W-1:0] w_den;
    aoc_pkg::t_side            w_side;
    aoc_pkg::t_side [ND-1:0]   r_side;
    logic [aoc_pkg::N_COL-1:0][SB-1:0] w_quo;
    aoc_pkg::t_side            w_so;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= 16'hFFFF;
            r_bcc     <= 3'd4;
            r_oha     <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aoc_pkg::CFG_OPACITY:   r_opacity <= i_cfg_data;
                aoc_pkg::CFG_BASE_CHAN: r_bcc     <= i_cfg_data[2:0];
                aoc_pkg::CFG_OVER_ALPH: r_oha     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_bcc == 3'd0) begin
            w_chans = 3'd1;
        end else if (r_bcc > 3'd4) begin
            w_chans = 3'd4;
        end else begin
            w_chans = r_bcc;
        end
        w_cfg.opacity    = r_opacity;
        w_cfg.alpha_used = (w_chans == 3'd4);
        w_cfg.ncol       = (w_chans >= 3'd3) ? 2'd3 : w_chans[1:0];
        w_cfg.over_alpha = r_oha;
    end

    // single stall for the whole pipeline
    assign w_go       = !r_v[NT-1] || i_out_ready;
    assign w_en       = {NT{w_go}};
    assign o_in_ready = w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_go) begin
            r_v <= {r_v[NT-2:0], i_in_valid};
        end
    end

    aoc_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[NF-1:0]),
        .i_data (i_in_data),
        .i_cfg  (w_cfg),
        .o_num  (w_num),
        .o_den  (w_den),
        .o_side (w_side)
    );

    for (genvar j = 0; j < aoc_pkg::N_COL; j++) begin : g_lane
        aoc_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (w_en[NT-1:NF]),
            .i_num (w_num[j]),
            .i_den (w_den),
            .o_quo (w_quo[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_side <= {r_side[ND-2:0], w_side};
        end
    end
    assign w_so = r_side[ND-1];

    always_comb begin
        o_out_data.out_red   = (!w_so.rzero && w_so.ncol >= 2'd1) ? w_quo[2] : '0;
        o_out_data.out_green = (!w_so.rzero && w_so.ncol >= 2'd2) ? w_quo[1] : '0;
        o_out_data.out_blue  = (!w_so.rzero && w_so.ncol >= 2'd3) ? w_quo[0] : '0;
        o_out_data.out_alpha = w_so.alpha_used ? w_so.alpha : aoc_pkg::FS;
    end

    assign o_out_valid = r_v[NT-1];
endmodule

[hdl/aoc_checker.sv]
// ----------------------------------------------------------------------------
// aoc_checker
// port level checks for the alpha over compositor
// ----------------------------------------------------------------------------
module aoc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input aoc_pkg::t_out o_out_data,
    input logic          o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready && o_cfg_ready)
        else $error("input refused with free output");
endmodule

bind alpha_over_composite_with_opacity aoc_checker u_aoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);
